### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define EWC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("implication check failed");

// Condition that must never hold outside reset.
`define EWC_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

### design/ewc_pkg.sv
// Package with the types, constants and sizes of the correction lookup unit.
`default_nettype none
package ewc_pkg;

  localparam int TABLE_SIZE = 32;
  localparam int HALF_W     = $clog2(TABLE_SIZE / 2 + 1);
  localparam int CELL_W     = $clog2(TABLE_SIZE);
  localparam int ADDR_W     = 3 * HALF_W;
  localparam int BANK_DEPTH = 1 << ADDR_W;
  localparam int NUM_BANKS  = 8;
  localparam int RES_LAT    = 10;

  localparam logic [31:0] SCALE_RESET = 32'd4194304;
  localparam logic [16:0] ONE_Q16     = 17'd65536;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [5:0]         grid_i;
    logic [5:0]         grid_j;
    logic [5:0]         grid_k;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] entry_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] corr_x;
    logic signed [31:0] corr_y;
    logic signed [31:0] corr_z;
  } res_t;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Query control handed from the address stage to the blend pipeline.
  // Index 0 of each array is the x axis.
  typedef struct packed {
    logic            valid;
    logic [2:0]      nonneg;
    logic [2:0]      par;
    logic [2:0][16:0] w_lo;
    logic [2:0][16:0] w_hi;
  } blend_ctl_t;

endpackage
`default_nettype wire

### design/ewc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ewc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/ewc_axis.sv
// Splits one scaled coordinate into a clamped cell index and a Q.16 fraction.
`default_nettype none
module ewc_axis (
  input  wire logic [63:0]                 u,
  output logic      [ewc_pkg::CELL_W-1:0]  cidx,
  output logic      [16:0]                 frac
);

  localparam logic [63:0] EDGE_BASE = 64'(ewc_pkg::TABLE_SIZE - 1) << 32;

  logic [63:0] rest;
  logic [47:0] f;

  always_comb begin
    rest = u - EDGE_BASE;
    f    = rest[63:16];
    if (u[63:32] >= 32'(ewc_pkg::TABLE_SIZE)) begin
      // Past the far edge: stay in the last cell and saturate the fraction.
      cidx = ewc_pkg::CELL_W'(ewc_pkg::TABLE_SIZE - 1);
      frac = (f > 48'(ewc_pkg::ONE_Q16)) ? ewc_pkg::ONE_Q16 : f[16:0];
    end else begin
      cidx = u[32 +: ewc_pkg::CELL_W];
      frac = {1'b0, u[31:16]};
    end
  end

endmodule
`default_nettype wire

### design/ewc_blend.sv
// Trilinear blend pipeline: corner weights, products, sum, rounding, saturation.
`default_nettype none
module ewc_blend (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ewc_pkg::blend_ctl_t ctl,
  input  wire ewc_pkg::entry_t     bank_q [ewc_pkg::NUM_BANKS],
  output logic                     done,
  output ewc_pkg::res_t            res
);

  // Stage 3: x-y weights and a copy of the bank data.
  logic                v3;
  logic [2:0]          nn3, par3;
  logic [16:0]         wxy3 [4];
  logic [1:0][16:0]    wz3;
  ewc_pkg::entry_t     q3 [ewc_pkg::NUM_BANKS];
  // Stage 4: full corner weights and corner-ordered data.
  logic                v4;
  logic [2:0]          nn4;
  logic [16:0]         wt4 [8];
  ewc_pkg::entry_t     d4 [8];
  // Stage 5..8: products and the adder tree, per component.
  logic                v5, v6, v7, v8;
  logic [2:0]          nn5, nn6, nn7, nn8;
  logic signed [48:0]  p5 [8][3];
  logic signed [49:0]  s6 [4][3];
  logic signed [50:0]  s7 [2][3];
  logic signed [51:0]  s8 [3];

  logic [33:0]         wxy_full [4];
  logic [33:0]         wt_full [8];
  logic signed [31:0]  res_c [3];

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      wxy_full[n] = (n[0] ? 34'(ctl.w_hi[0]) : 34'(ctl.w_lo[0]))
                  * (n[1] ? 34'(ctl.w_hi[1]) : 34'(ctl.w_lo[1])) + 34'd32768;
    end
    for (int c = 0; c < 8; c++) begin
      wt_full[c] = 34'(wxy3[c % 4]) * 34'(wz3[c / 4]) + 34'd32768;
    end
  end

  // Rounding half up, sign application and saturation of one component.
  function automatic logic signed [31:0] finish(input logic signed [51:0] sum,
                                                 input logic negate);
    logic signed [51:0] t;
    logic signed [37:0] r;
    t = sum + 52'sd32768;
    r = 38'(t >>> 16);
    if (negate) begin
      r = -r;
    end
    if (r > 38'sh7FFFFFFF) begin
      finish = 32'sh7FFFFFFF;
    end else if (r < -38'sh80000000) begin
      finish = 32'sh80000000;
    end else begin
      finish = r[31:0];
    end
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      res_c[a] = finish(s8[a], nn8[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      done <= 1'b0;
    end else begin
      v3   <= ctl.valid;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      v8   <= v7;
      done <= v8;
    end
  end

  always_ff @(posedge clk) begin
    nn3  <= ctl.nonneg;
    par3 <= ctl.par;
    wz3  <= {ctl.w_hi[2], ctl.w_lo[2]};
    for (int n = 0; n < 4; n++) begin
      wxy3[n] <= wxy_full[n][32:16];
    end
    q3 <= bank_q;

    nn4 <= nn3;
    for (int c = 0; c < 8; c++) begin
      wt4[c] <= wt_full[c][32:16];
      // Corner c sits in the bank whose parity is the corner offset xor the cell parity.
      d4[c]  <= q3[3'(c) ^ par3];
    end

    nn5 <= nn4;
    for (int c = 0; c < 8; c++) begin
      p5[c][0] <= d4[c].x * $signed({1'b0, wt4[c]});
      p5[c][1] <= d4[c].y * $signed({1'b0, wt4[c]});
      p5[c][2] <= d4[c].z * $signed({1'b0, wt4[c]});
    end

    nn6 <= nn5;
    nn7 <= nn6;
    nn8 <= nn7;
    for (int a = 0; a < 3; a++) begin
      for (int n = 0; n < 4; n++) begin
        s6[n][a] <= 50'(p5[2*n][a]) + 50'(p5[2*n+1][a]);
      end
      for (int n = 0; n < 2; n++) begin
        s7[n][a] <= 51'(s6[2*n][a]) + 51'(s6[2*n+1][a]);
      end
      s8[a] <= 52'(s7[0][a]) + 52'(s7[1][a]);
    end

    res.corr_x <= res_c[0];
    res.corr_y <= res_c[1];
    res.corr_z <= res_c[2];
  end

endmodule
`default_nettype wire

### design/ewald_correction_trilinear_lookup_unit.sv
// Top level of the Ewald correction trilinear lookup unit.
// Throughput: one transfer per clock, writes and queries alike; busy stays low.
// A query's result reaches res, with done high, through these registers in order: input
//   register, scale multiply, bank read, two weight multiplies, component multiply, three
//   adder levels, output register; writes give no result, and since the receiver cannot
//   stall, results never wait. Synchronous reset clears the valids and sets interp_scale
//   to 64.0; the table is not cleared and must be loaded before use.
`default_nettype none
module ewald_correction_trilinear_lookup_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire ewc_pkg::cmd_t cmd,
  output logic               done,
  output ewc_pkg::res_t      res,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata
);

  localparam int HW = ewc_pkg::HALF_W;
  localparam int CW = ewc_pkg::CELL_W;

  // The table is split into eight banks by the parity of each grid index, so
  // the eight corners of any cell land in eight different banks and a whole
  // query is served by one read of every bank in the same cycle.

  logic [31:0] interp_scale;

  // Stage 0: accepted command with folded position magnitudes.
  logic                  v0;
  ewc_pkg::op_t          op0;
  logic [2:0]            nn0;
  logic [31:0]           mag0 [3];
  logic [5:0]            gi0, gj0, gk0;
  ewc_pkg::entry_t       ent0;

  // Stage 1: scaled coordinates; the table is read or written from here.
  logic                  v1;
  ewc_pkg::op_t          op1;
  logic [2:0]            nn1;
  logic [63:0]           u1 [3];
  logic [5:0]            gi1, gj1, gk1;
  ewc_pkg::entry_t       ent1;

  logic [31:0]           pos_in [3];
  logic [CW-1:0]         cidx [3];
  logic [16:0]           frac [3];
  logic                  wr_ok;
  logic [ewc_pkg::ADDR_W-1:0] wr_addr;
  logic [2:0]            wr_bank;
  logic [ewc_pkg::ADDR_W-1:0] rd_addr [ewc_pkg::NUM_BANKS];
  ewc_pkg::entry_t       bank_q [ewc_pkg::NUM_BANKS];
  ewc_pkg::blend_ctl_t   ctl;

  assign busy = 1'b0;

  assign pos_in[0] = cmd.pos_x;
  assign pos_in[1] = cmd.pos_y;
  assign pos_in[2] = cmd.pos_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_scale <= ewc_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      interp_scale <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    op0  <= cmd.op;
    gi0  <= cmd.grid_i;
    gj0  <= cmd.grid_j;
    gk0  <= cmd.grid_k;
    ent0 <= '{x: cmd.entry_x, y: cmd.entry_y, z: cmd.entry_z};
    for (int a = 0; a < 3; a++) begin
      // The magnitude of the most negative position still fits in 32 unsigned bits.
      nn0[a]  <= !pos_in[a][31];
      mag0[a] <= pos_in[a][31] ? 32'(32'd0 - pos_in[a]) : pos_in[a];
    end

    op1  <= op0;
    nn1  <= nn0;
    gi1  <= gi0;
    gj1  <= gj0;
    gk1  <= gk0;
    ent1 <= ent0;
    for (int a = 0; a < 3; a++) begin
      u1[a] <= 64'(mag0[a]) * 64'(interp_scale);
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    ewc_axis u_axis (
      .u    (u1[a]),
      .cidx (cidx[a]),
      .frac (frac[a])
    );
  end

  // Bank addressing: bank bit a is the parity of the axis-a index, and the
  // address within the bank is the index halved, one field per axis.
  always_comb begin
    logic [CW:0] idx;
    wr_ok   = v1 && (op1 == ewc_pkg::OP_WRITE)
           && (gi1 <= 6'(ewc_pkg::TABLE_SIZE))
           && (gj1 <= 6'(ewc_pkg::TABLE_SIZE))
           && (gk1 <= 6'(ewc_pkg::TABLE_SIZE));
    wr_bank = {gk1[0], gj1[0], gi1[0]};
    wr_addr = {HW'(gk1 >> 1), HW'(gj1 >> 1), HW'(gi1 >> 1)};
    for (int b = 0; b < ewc_pkg::NUM_BANKS; b++) begin
      for (int a = 0; a < 3; a++) begin
        // The corner offset that falls into this bank on this axis.
        idx = (CW+1)'(cidx[a]) + (CW+1)'(b[a] ^ cidx[a][0]);
        rd_addr[b][a*HW +: HW] = HW'(idx >> 1);
      end
    end
  end

  for (genvar b = 0; b < ewc_pkg::NUM_BANKS; b++) begin : g_bank
    ewc_ram #(
      .WIDTH (ewc_pkg::ENTRY_W),
      .DEPTH (ewc_pkg::BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_ok && (wr_bank == 3'(b))),
      .waddr (wr_addr),
      .wdata (ent1),
      .raddr (rd_addr[b]),
      .rdata (bank_q[b])
    );
  end

  // Query control registered alongside the bank read.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= v1 && (op1 == ewc_pkg::OP_QUERY);
    end
    ctl.nonneg <= nn1;
    for (int a = 0; a < 3; a++) begin
      ctl.par[a]  <= cidx[a][0];
      ctl.w_lo[a] <= ewc_pkg::ONE_Q16 - frac[a];
      ctl.w_hi[a] <= frac[a];
    end
  end

  ewc_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .bank_q (bank_q),
    .done   (done),
    .res    (res)
  );

endmodule
`default_nettype wire

### design/ewc_checker.sv
// Port-level checker for the lookup unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ewc_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire ewc_pkg::cmd_t cmd,
  input wire logic          done
);

  logic q_acc, w_acc;

  assign q_acc = start && !busy && (cmd.op == ewc_pkg::OP_QUERY);
  assign w_acc = start && !busy && (cmd.op == ewc_pkg::OP_WRITE);

  `EWC_ASSERT_NEVER(a_never_busy, clk, rst, busy)
  `EWC_ASSERT_IMPLY(a_query_done, clk, rst, q_acc, ##(ewc_pkg::RES_LAT) done)
  `EWC_ASSERT_IMPLY(a_write_silent, clk, rst, w_acc, ##(ewc_pkg::RES_LAT) !done)

endmodule

bind ewald_correction_trilinear_lookup_unit ewc_checker u_ewc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done)
);
`default_nettype wire
